[hw/rtl/ita_pkg.sv]
// ----------------------------------------------------------------------------
// Interval lane assigner package
// Shared types and fixed widths for the interval lane assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package ita_pkg;

  // Width of the start and end timestamps.
  localparam int unsigned TIME_W = 48;

  // Width of the lane number carried on the result channel.
  localparam int unsigned LANE_OUT_W = 4;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

endpackage : ita_pkg

`default_nettype wire

[hw/rtl/interval_track_assign.sv]
// ----------------------------------------------------------------------------
// Interval lane assigner
// Places each incoming time interval in the first lane (in scan order) whose
// latest interval does not overlap it, else opens a new lane if one is free.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one word per interval:
// span_start, span_end and group_first. group_first empties every lane before
// the interval is placed. The output channel (out_valid/out_ready) returns one
// word per interval: lane_index, opened_new and overflow. The configuration
// channel (cfg_valid/cfg_ready/cfg_data) sets the search policy: 0 scans from
// lane zero, 1 scans round-robin from the lane last used. It is always ready
// and should only be written while the block is idle.
// Timing: the lanes live in a single-port memory read one lane per cycle
// through a two-stage read and compare loop. An interval reads the lanes in
// turn until one fits (or all open lanes when none fits); with no lane open
// it goes straight to the finish step. The next word is accepted only once
// the block is back in idle, after the result has been written out.
// Reset (rst, synchronous) closes all lanes, selects first-fit and drops any
// pending result. A stalled receiver leaves the result in the output register
// and a new word may still be accepted; its result waits until that register
// has been emptied.
`default_nettype none

module interval_track_assign #(
  parameter int unsigned MAX_LANES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write channel
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic                          cfg_data,
  // interval input channel
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [ita_pkg::TIME_W-1:0]    span_start,
  input  wire logic [ita_pkg::TIME_W-1:0]    span_end,
  input  wire logic                          group_first,
  // lane result channel
  output      logic                          out_valid,
  input  wire logic                          out_ready,
  output      logic [ita_pkg::LANE_OUT_W-1:0] lane_index,
  output      logic                          opened_new,
  output      logic                          overflow
);

  import ita_pkg::*;

  // Width of a lane number and of a lane count (which may equal MAX_LANES).
  localparam int unsigned LW = (MAX_LANES > 1) ? $clog2(MAX_LANES) : 1;
  localparam int unsigned CW = $clog2(MAX_LANES + 1);
  localparam logic [CW-1:0] LANES_FULL = CW'(MAX_LANES);

  state_t state, state_next;

  // Architectural state.
  logic          search_policy;
  logic [CW-1:0] lanes_open;
  logic [LW-1:0] last_used_lane;

  // Interval under work.
  logic [TIME_W-1:0] item_start;
  logic [TIME_W-1:0] item_end;

  // Scan sequencer: issue side and compare side of the memory read.
  logic [LW-1:0] iss_idx;
  logic [CW-1:0] iss_left;
  logic          chk_valid;
  logic [LW-1:0] chk_lane;
  logic          found;
  logic [LW-1:0] found_lane;

  // Lane memory: {start, end} of the latest interval in each lane.
  logic [2*TIME_W-1:0] lane_mem [MAX_LANES];
  logic [2*TIME_W-1:0] rd_word;

  // Control decoded from the state.
  logic          in_take;
  logic          rd_en;
  logic          hit;
  logic          scan_end;
  logic          fin_go;
  logic          room;
  logic          mem_we;
  logic [LW-1:0] wr_lane;

  logic [CW-1:0] eff_open;
  logic [LW-1:0] eff_last;
  logic [CW:0]   idx_inc;
  logic [LW-1:0] idx_wrap;
  logic          fits;
  logic [LW+LANE_OUT_W-1:0] lane_ext;

  assign cfg_ready = 1'b1;

  // A group start behaves as if every lane were closed.
  assign eff_open = group_first ? '0 : lanes_open;
  assign eff_last = group_first ? '0 : last_used_lane;

  // Next lane in scan order, wrapping at the number of open lanes.
  assign idx_inc  = (CW + 1)'(iss_idx) + (CW + 1)'(1);
  assign idx_wrap = (idx_inc == {1'b0, lanes_open}) ? '0 : idx_inc[LW-1:0];

  // The stored interval fits unless the two intervals overlap.
  assign fits = !((rd_word[2*TIME_W-1:TIME_W] < item_end) &&
                  (item_start < rd_word[TIME_W-1:0]));

  assign room = (lanes_open != LANES_FULL);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (eff_open == '0) ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || scan_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (fin_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    hit      = 1'b0;
    scan_end = 1'b0;
    fin_go   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        hit      = chk_valid && fits;
        scan_end = chk_valid && !fits && (iss_left == '0);
        rd_en    = !hit && (iss_left != '0);
      end
      ST_FINISH: begin
        fin_go = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  assign in_take = in_valid && in_ready;
  assign mem_we  = fin_go && (found || room);
  assign wr_lane = found ? found_lane : lanes_open[LW-1:0];

  // Lane memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lane_mem[wr_lane] <= {item_start, item_end};
    end
    if (rd_en) begin
      rd_word <= lane_mem[iss_idx];
    end
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      search_policy <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      search_policy <= cfg_data;
    end
  end

  // Input capture and scan bookkeeping.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_start <= span_start;
      item_end   <= span_end;
      iss_idx    <= search_policy ? eff_last : '0;
      iss_left   <= eff_open;
      found      <= 1'b0;
      found_lane <= '0;
    end else if (state == ST_SCAN) begin
      if (hit) begin
        found      <= 1'b1;
        found_lane <= chk_lane;
      end
      if (rd_en) begin
        chk_lane <= iss_idx;
        iss_idx  <= idx_wrap;
        iss_left <= iss_left - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= rd_en;
    end
  end

  // Lane bookkeeping: a group start empties the lanes on acceptance, the
  // placement itself is committed when the result is written out.
  always_ff @(posedge clk) begin
    if (rst) begin
      lanes_open     <= '0;
      last_used_lane <= '0;
    end else if (in_take && group_first) begin
      lanes_open     <= '0;
      last_used_lane <= '0;
    end else if (fin_go) begin
      if (found) begin
        if (search_policy) begin
          last_used_lane <= found_lane;
        end
      end else if (room) begin
        lanes_open     <= lanes_open + CW'(1);
        last_used_lane <= lanes_open[LW-1:0];
      end
    end
  end

  // Result register.
  assign lane_ext = {{LANE_OUT_W{1'b0}}, wr_lane};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      lane_index <= (found || room) ? lane_ext[LANE_OUT_W-1:0] : '0;
      opened_new <= !found && room;
      overflow   <= !found && !room;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The number of open lanes never exceeds the lane count.
  a_lanes_bound: assert property (@(posedge clk) disable iff (rst)
    lanes_open <= LANES_FULL)
    else $error("more lanes open than exist");

  // The round-robin start lane is always an open lane.
  a_last_open: assert property (@(posedge clk) disable iff (rst)
    (lanes_open != '0) |-> ((CW + 1)'(last_used_lane) < (CW + 1)'(lanes_open)))
    else $error("last used lane is not open");

  // An overflow result carries neither a lane nor a new-lane flag.
  a_overflow_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflow) |-> (!opened_new && (lane_index == '0)))
    else $error("overflow result carries a lane");

  // Opening a lane grows the lane count by exactly one.
  a_open_grows: assert property (@(posedge clk) disable iff (rst)
    (fin_go && !found && room) |=> (lanes_open == $past(lanes_open) + CW'(1)))
    else $error("new lane did not raise the lane count");

endmodule : interval_track_assign

`default_nettype wire
